// ===== design/fdsm_pkg.sv =====
// Shared types, codes and constants for the four-digit seven-segment display mux.
// Used by fdsm_encode, fdsm_scan and four_digit_seven_segment_mux; no dependencies.
package fdsm_pkg;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      CSR_SCAN_LAG       = 2'd0,
      CSR_SEGMENT_ACTIVE = 2'd1,
      CSR_DIGIT_ACTIVE   = 2'd2,
      CSR_DISPLAY_ENABLE = 2'd3
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int LAG_WIDTH       = 16;
   localparam int VALUE_WIDTH     = 16;
   localparam int MAG_WIDTH       = 14;
   localparam int NUM_DIGITS      = 4;

   localparam logic [LAG_WIDTH-1:0] LAG_RESET = 16'd100;

   localparam logic [7:0] PAT_ZERO  = 8'b0011_1111;
   localparam logic [7:0] PAT_MINUS = 8'b0100_0000;
   localparam logic [7:0] PAT_BLANK = 8'b0000_0000;

   localparam logic signed [VALUE_WIDTH-1:0] POS_MAX = 16'sd9999;
   localparam logic signed [VALUE_WIDTH-1:0] NEG_MIN = -16'sd999;
   localparam int RADIX = 10;

   // reciprocal multipliers: exact quotients for magnitudes up to 9999
   localparam int DIV10_MUL   = 52429;  // >> 19
   localparam int DIV100_MUL  = 5243;   // >> 19
   localparam int DIV1000_MUL = 8389;   // >> 23

   typedef logic [7:0] pattern_type;
   typedef logic [NUM_DIGITS-1:0][7:0] pattern_set_type;

   typedef struct packed {
      logic [LAG_WIDTH-1:0] scan_lag;
      logic                 segment_active_high;
      logic                 digit_active_high;
      logic                 display_enable;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic tick;
      logic clear_drive;
   } step_type;

   function automatic pattern_type seg_of(input logic [3:0] digit);
      pattern_type p;
      unique case (digit)
         4'd0:    p = PAT_ZERO;
         4'd1:    p = 8'h06;
         4'd2:    p = 8'h5B;
         4'd3:    p = 8'h4F;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'h6D;
         4'd6:    p = 8'h7D;
         4'd7:    p = 8'h07;
         4'd8:    p = 8'h7F;
         4'd9:    p = 8'h6F;
         default: p = PAT_BLANK;
      endcase
      return p;
   endfunction

endpackage

// ===== design/fdsm_encode.sv =====
// Value to four seven-segment patterns: range check, constant-divisor digit split, blanking.
// Depends on fdsm_pkg.
module fdsm_encode (
   input  logic [fdsm_pkg::VALUE_WIDTH-1:0] value,
   output fdsm_pkg::pattern_set_type        patterns
);
   import fdsm_pkg::*;

   logic                         is_pos;
   logic                         is_neg;
   logic [VALUE_WIDTH-1:0]       mag_full;
   logic [MAG_WIDTH-1:0]         mag;
   logic [28:0]                  prod1;
   logic [25:0]                  prod2;
   logic [26:0]                  prod3;
   logic [9:0]                   q1;
   logic [6:0]                   q2;
   logic [3:0]                   q3;
   logic [3:0]                   d0;
   logic [3:0]                   d1;
   logic [3:0]                   d2;
   logic [3:0]                   d3;

   assign is_pos   = ($signed(value) >= 16'sd0) && ($signed(value) <= POS_MAX);
   assign is_neg   = ($signed(value) < 16'sd0) && ($signed(value) >= NEG_MIN);
   assign mag_full = is_neg ? VALUE_WIDTH'(-value) : value;
   assign mag      = mag_full[MAG_WIDTH-1:0];

   assign prod1 = 29'(mag) * 29'(DIV10_MUL);
   assign prod2 = 26'(mag) * 26'(DIV100_MUL);
   assign prod3 = 27'(mag) * 27'(DIV1000_MUL);
   assign q1    = prod1[28:19];
   assign q2    = prod2[25:19];
   assign q3    = prod3[26:23];

   assign d0 = 4'(mag - 14'(q1) * 14'(RADIX));
   assign d1 = 4'(q1 - 10'(q2) * 10'(RADIX));
   assign d2 = 4'(q2 - 7'(q3) * 7'(RADIX));
   assign d3 = q3;

   always_comb begin
      if (is_pos || is_neg) begin
         patterns[0] = seg_of(d0);
         patterns[1] = (d3 == 4'd0 && d2 == 4'd0 && d1 == 4'd0) ? PAT_BLANK : seg_of(d1);
         patterns[2] = (d3 == 4'd0 && d2 == 4'd0) ? PAT_BLANK : seg_of(d2);
         if (is_neg) begin
            patterns[3] = PAT_MINUS;
         end else begin
            patterns[3] = (d3 == 4'd0) ? PAT_BLANK : seg_of(d3);
         end
      end else begin
         patterns = {NUM_DIGITS{PAT_MINUS}};
      end
   end

endmodule

// ===== design/fdsm_scan.sv =====
// Scan state: stored patterns, prescaler, scan index and the active-high line drives.
// Depends on fdsm_pkg.
module fdsm_scan #(
   parameter int PRESCALE_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fdsm_pkg::step_type         step,
   input  fdsm_pkg::cfg_type          cfg,
   input  fdsm_pkg::pattern_set_type  patterns,
   output logic [7:0]                 segment_next,
   output logic [3:0]                 digit_next
);
   import fdsm_pkg::*;

   localparam int CMP_WIDTH = (PRESCALE_WIDTH + 1 > LAG_WIDTH) ? PRESCALE_WIDTH + 1 : LAG_WIDTH;

   pattern_set_type             patterns_ff;
   logic [1:0]                  scan_index_ff;
   logic [PRESCALE_WIDTH-1:0]   count_ff;
   logic [7:0]                  segment_ff;
   logic [3:0]                  digit_ff;

   logic [CMP_WIDTH-1:0]        count_in;
   logic                        active_tick;
   logic                        hit;
   logic                        saturated;

   assign count_in    = CMP_WIDTH'(count_ff) + CMP_WIDTH'(1);
   assign active_tick = step.tick && cfg.display_enable;
   assign hit         = count_in > CMP_WIDTH'(cfg.scan_lag);
   assign saturated   = count_in[PRESCALE_WIDTH];

   always_comb begin
      segment_next = segment_ff;
      digit_next   = digit_ff;
      if (active_tick && hit) begin
         segment_next = patterns_ff[scan_index_ff];
         digit_next   = 4'b0001 << scan_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         patterns_ff   <= '0;
         scan_index_ff <= 2'd3;
         count_ff      <= '0;
         segment_ff    <= '0;
         digit_ff      <= '0;
      end else begin
         if (step.load) begin
            patterns_ff <= patterns;
         end
         if (step.clear_drive) begin
            segment_ff <= '0;
            digit_ff   <= '0;
         end else begin
            segment_ff <= segment_next;
            digit_ff   <= digit_next;
         end
         if (active_tick) begin
            if (hit) begin
               count_ff      <= '0;
               scan_index_ff <= scan_index_ff - 2'd1;
            end else if (!saturated) begin
               count_ff <= count_in[PRESCALE_WIDTH-1:0];
            end
         end
      end
   end

endmodule

// ===== design/four_digit_seven_segment_mux.sv =====
// Top level of the four-digit seven-segment display mux: request/result registers and CSRs.
// Depends on fdsm_pkg, fdsm_encode and fdsm_scan.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_ready   req_op, req_value
//   rsp       out        rsp_valid/rsp_ready   rsp_segment_lines, rsp_digit_lines
//   csr       in         csr_valid/csr_ready   csr_index, csr_data
//
// Each request passes the request register, then encode and scan logic into the
// result register. One request per cycle sustained while rsp_ready stays high.
// A stalled result holds; the request register still takes one request meanwhile.
// Synchronous reset clears the valid flags and sets CSR defaults; csr_ready is always high.
module four_digit_seven_segment_mux #(
   parameter int PRESCALE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [fdsm_pkg::VALUE_WIDTH-1:0]     req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [7:0]                           rsp_segment_lines,
   output logic [3:0]                           rsp_digit_lines,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fdsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [fdsm_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import fdsm_pkg::*;

   cfg_type                 cfg_ff;
   logic                    in_valid_ff;
   op_type                  in_op_ff;
   logic [VALUE_WIDTH-1:0]  in_value_ff;
   logic                    rsp_valid_ff;
   logic [7:0]              segment_ff;
   logic [3:0]              digit_ff;

   logic                    advance;
   logic                    csr_write;
   step_type                step;
   pattern_set_type         patterns;
   logic [7:0]              segment_next;
   logic [3:0]              digit_next;
   logic [7:0]              segment_in;
   logic [3:0]              digit_in;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign step.load        = advance && (in_op_ff == OP_LOAD);
   assign step.tick        = advance && (in_op_ff == OP_TICK);
   assign step.clear_drive = csr_write && (csr_index_type'(csr_index) == CSR_DISPLAY_ENABLE)
                             && !csr_data[0];

   fdsm_encode u_encode (
      .value    (in_value_ff),
      .patterns (patterns)
   );

   fdsm_scan #(
      .PRESCALE_WIDTH (PRESCALE_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .cfg          (cfg_ff),
      .patterns     (patterns),
      .segment_next (segment_next),
      .digit_next   (digit_next)
   );

   assign segment_in = (cfg_ff.display_enable ? segment_next : 8'h00)
                       ^ {8{!cfg_ff.segment_active_high}};
   assign digit_in   = (cfg_ff.display_enable ? digit_next : 4'h0)
                       ^ {4{!cfg_ff.digit_active_high}};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_lag            <= LAG_RESET;
         cfg_ff.segment_active_high <= 1'b1;
         cfg_ff.digit_active_high   <= 1'b1;
         cfg_ff.display_enable      <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCAN_LAG:       cfg_ff.scan_lag            <= csr_data[LAG_WIDTH-1:0];
            CSR_SEGMENT_ACTIVE: cfg_ff.segment_active_high <= csr_data[0];
            CSR_DIGIT_ACTIVE:   cfg_ff.digit_active_high   <= csr_data[0];
            CSR_DISPLAY_ENABLE: cfg_ff.display_enable      <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_op_ff    <= op_type'(req_op);
         in_value_ff <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         segment_ff <= segment_in;
         digit_ff   <= digit_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_lines = segment_ff;
   assign rsp_digit_lines   = digit_ff;

`ifndef SYNTHESIS
   a_digit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(digit_next))
      else $error("more than one digit driven");

   a_disabled_dark: assert property (@(posedge clock) disable iff (reset)
      !cfg_ff.display_enable |-> (digit_next == 4'h0 && segment_next == 8'h00))
      else $error("drive active while display disabled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled without a blocked result");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed request produced no result");
`endif

endmodule
